// ===== sv/bounded_xorshift_random_assert.svh =====
// Assertion macros for the bounded xorshift random source.
// Needs clk and rst_n in scope wherever a macro is used.
`ifndef BOUNDED_XORSHIFT_RANDOM_ASSERT_SVH
`define BOUNDED_XORSHIFT_RANDOM_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define BXR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define BXR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bxr_pkg.sv =====
// Shared constants and controller/datapath interface types.
// No dependencies.
package bxr_pkg;

    localparam int unsigned BoundW = 63;
    localparam int unsigned WordW  = 64;
    localparam int unsigned CntW   = 6;

    localparam logic [WordW-1:0] GoldenConst = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WordW-1:0] OutMult     = 64'd2685821657736338717;
    localparam int unsigned      ShiftA      = 12;
    localparam int unsigned      ShiftB      = 25;
    localparam int unsigned      ShiftC      = 27;

    localparam logic [1:0] MulLoLo = 2'd0;
    localparam logic [1:0] MulLoHi = 2'd1;
    localparam logic [1:0] MulHiLo = 2'd2;

    typedef struct packed {
        logic       load_bound;
        logic       div_start;
        logic       div_src_draw;
        logic       div_step;
        logic       set_limit;
        logic       xs_step;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       load_out;
    } bxr_cmd_t;

    typedef struct packed {
        logic bound_zero;
        logic reject;
        logic state_zero;
    } bxr_stat_t;

endpackage

// ===== sv/bxr_dp.sv =====
// Datapath: generator state, shared 32x32 multiplier, serial remainder unit.
// Depends on bxr_pkg.
module bxr_dp
    import bxr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BoundW-1:0] bound,
    input  logic              seed_we,
    input  logic [WordW-1:0]  seed,
    input  bxr_cmd_t          cmd,
    output bxr_stat_t         stat,
    output logic [BoundW-1:0] value,
    output logic              bad_bound
);

    logic [WordW-1:0]  state_reg, state_next;
    logic [BoundW-1:0] bound_reg;
    logic [WordW-1:0]  limit_reg;
    logic [WordW-1:0]  draw_reg;
    logic [WordW-1:0]  rem_reg;
    logic [WordW-1:0]  dvd_reg;
    logic [BoundW-1:0] value_reg;
    logic              bad_reg;

    logic [WordW-1:0]  xs_a, xs_b, xs_c, xs_in;
    logic [31:0]       mul_a, mul_b;
    logic [WordW-1:0]  prod;
    logic [WordW-1:0]  rem_sh;
    logic [WordW-1:0]  bound_ext;

    // xorshift step, zero state replaced by the golden constant
    always_comb
    begin
        xs_in = (state_reg == '0) ? GoldenConst : state_reg;
        xs_a  = xs_in ^ (xs_in >> ShiftA);
        xs_b  = xs_a ^ (xs_a << ShiftB);
        xs_c  = xs_b ^ (xs_b >> ShiftC);
    end

    always_comb
    begin
        state_next = state_reg;
        if (seed_we)
            state_next = (seed != '0) ? seed : GoldenConst;
        else if (cmd.xs_step)
            state_next = xs_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= GoldenConst;
        else
            state_reg <= state_next;
    end

    // one 32x32 partial product per cycle; only the low 64 bits are kept
    always_comb
    begin
        mul_a = state_reg[31:0];
        mul_b = OutMult[31:0];
        unique case (cmd.mul_sel)
            MulLoLo: begin mul_a = state_reg[31:0];  mul_b = OutMult[31:0];  end
            MulLoHi: begin mul_a = state_reg[31:0];  mul_b = OutMult[63:32]; end
            MulHiLo: begin mul_a = state_reg[63:32]; mul_b = OutMult[31:0];  end
            default: begin mul_a = state_reg[31:0];  mul_b = OutMult[31:0];  end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    assign bound_ext = {1'b0, bound_reg};
    assign rem_sh    = {rem_reg[WordW-2:0], dvd_reg[WordW-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.load_bound)
            bound_reg <= bound;
        if (cmd.mul_en)
        begin
            if (cmd.mul_sel == MulLoLo)
                draw_reg <= prod;
            else
                draw_reg <= draw_reg + {prod[31:0], 32'd0};
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            dvd_reg <= cmd.div_src_draw ? draw_reg : '1;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= (rem_sh >= bound_ext) ? (rem_sh - bound_ext) : rem_sh;
            dvd_reg <= {dvd_reg[WordW-2:0], 1'b0};
        end
        // limit = all ones minus (all ones mod bound)
        if (cmd.set_limit)
            limit_reg <= ~rem_reg;
        if (cmd.load_out)
        begin
            value_reg <= (bound_reg == '0) ? '0 : rem_reg[BoundW-1:0];
            bad_reg   <= (bound_reg == '0);
        end
    end

    assign stat.bound_zero = (bound_reg == '0);
    assign stat.reject     = (draw_reg >= limit_reg);
    assign stat.state_zero = (state_reg == '0);
    assign value           = value_reg;
    assign bad_bound       = bad_reg;

endmodule

// ===== sv/bxr_ctrl.sv =====
// Sequencer for limit computation, draws, rejection and result hand-off.
// Depends on bxr_pkg.
module bxr_ctrl
    import bxr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  bxr_stat_t stat,
    output bxr_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_LDIV  = 4'd2;
    localparam logic [3:0] S_LIM   = 4'd3;
    localparam logic [3:0] S_XS    = 4'd4;
    localparam logic [3:0] S_M0    = 4'd5;
    localparam logic [3:0] S_M1    = 4'd6;
    localparam logic [3:0] S_M2    = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;
    localparam logic [3:0] S_DDIV  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]      st_reg, st_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            ov_reg, ov_next;
    logic            cnt_last;

    assign cnt_last = (cnt_reg == '1);

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        cmd      = '0;
        in_ready = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_bound = 1'b1;
                    st_next        = S_START;
                end
            end
            S_START:
            begin
                if (stat.bound_zero)
                    st_next = S_DONE;
                else
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    st_next       = S_LDIV;
                end
            end
            S_LDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last)
                    st_next = S_LIM;
            end
            S_LIM:
            begin
                cmd.set_limit = 1'b1;
                st_next       = S_XS;
            end
            S_XS:
            begin
                cmd.xs_step = 1'b1;
                st_next     = S_M0;
            end
            S_M0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MulLoLo;
                st_next     = S_M1;
            end
            S_M1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MulLoHi;
                st_next     = S_M2;
            end
            S_M2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MulHiLo;
                st_next     = S_CHK;
            end
            S_CHK:
            begin
                if (stat.reject)
                    st_next = S_XS;
                else
                begin
                    cmd.div_start    = 1'b1;
                    cmd.div_src_draw = 1'b1;
                    cnt_next         = '0;
                    st_next          = S_DDIV;
                end
            end
            S_DDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last)
                    st_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    st_next      = S_IDLE;
                end
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.load_out)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

// ===== sv/bounded_xorshift_random.sv =====
// Top level of the bounded xorshift64* random source.
// Depends on bxr_pkg, bxr_ctrl, bxr_dp and bounded_xorshift_random_assert.svh.
//
//   channel | handshake           | word
//   --------+---------------------+----------------------------
//   in      | in_valid / in_ready | bound [62:0]
//   out     | out_valid/out_ready | value [62:0], bad_bound
//   seed    | seed_we             | seed [63:0], no wait
//
// A word forms the rejection limit on the serial remainder unit (start, remainder
// steps, limit set), then draws (state step, three 32x32 partial products, limit
// compare) until one is accepted, and takes the final remainder on the same unit.
// A zero bound skips the limit, draws and remainder and goes to the hand-off.
// Reset loads the golden constant into the generator state and empties the
// output register. A finished word waits in the output register; the next
// bound is taken meanwhile and processed up to the hand-off, where it holds.
`include "bounded_xorshift_random_assert.svh"

module bounded_xorshift_random
    import bxr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BoundW-1:0] bound,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BoundW-1:0] value,
    output logic              bad_bound,
    input  logic              seed_we,
    input  logic [WordW-1:0]  seed
);

    bxr_cmd_t  cmd;
    bxr_stat_t stat;

    // Sequence the work: limit, draw loop with rejection, remainder, hand-off
    bxr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold generator state, partial-product accumulator and remainder unit
    bxr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .bound     (bound),
        .seed_we   (seed_we),
        .seed      (seed),
        .cmd       (cmd),
        .stat      (stat),
        .value     (value),
        .bad_bound (bad_bound)
    );

    // a zero bound always reports a zero value
    `BXR_ASSERT_NOW(a_bad_zero, out_valid && bad_bound, value == '0, "bad bound with nonzero value")
    // never overwrite a word still waiting on the output
    `BXR_ASSERT_NOW(a_no_overrun, cmd.load_out, !out_valid || out_ready, "output word overrun")
    // the generator state must never collapse to zero
    `BXR_ASSERT_NEXT(a_state_live, 1'b1, !stat.state_zero, "generator state reached zero")

endmodule

// ===== test/bxr_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the bounded xorshift64* random source: follows the seed
// port and both word channels, predicts each result and compares it.
// Depends on bxr_pkg for the port widths.
module bxr_result_checker
    import bxr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [BoundW-1:0] bound,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [BoundW-1:0] value,
    input  logic              bad_bound,
    input  logic              seed_we,
    input  logic [WordW-1:0]  seed,
    output int                fail_count,
    output int                pending,
    output int                checked,
    output int                redraws
);

    localparam logic [WordW-1:0] Golden   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WordW-1:0] Mult     = 64'd2685821657736338717;
    localparam logic [WordW-1:0] AllOnes  = {WordW{1'b1}};
    localparam int               MaxShown = 100;

    typedef struct packed {
        logic [BoundW-1:0] val;
        logic              bad;
    } draw_result_t;

    logic [WordW-1:0] gen_state;
    draw_result_t     due_results[$];
    draw_result_t     head;

    task automatic report_mismatch(input string what);
        if (fail_count < MaxShown)
            $display("[%0t] %s", $time, what);
        fail_count++;
    endtask

    // Advance the generator one step and return the scrambled draw.
    function automatic logic [WordW-1:0] next_draw();
        logic [WordW-1:0] x;
        x = (gen_state == '0) ? Golden : gen_state;
        x = x ^ (x >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        gen_state = x;
        return x * Mult;
    endfunction

    function automatic draw_result_t bounded_draw(input logic [BoundW-1:0] b);
        logic [WordW-1:0] wide;
        logic [WordW-1:0] ceiling;
        logic [WordW-1:0] d;
        logic [WordW-1:0] rem;
        draw_result_t     r;
        r.val = '0;
        r.bad = 1'b1;
        if (b == '0)
            return r;
        wide    = {1'b0, b};
        ceiling = AllOnes - (AllOnes % wide);
        d = next_draw();
        while (d >= ceiling)
        begin
            redraws++;
            d = next_draw();
        end
        rem   = d % wide;
        r.val = rem[BoundW-1:0];
        r.bad = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state = Golden;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            // Retire the result first: it always belongs to an older word.
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                    report_mismatch($sformatf("unexpected result value=%h bad_bound=%b",
                                              value, bad_bound));
                else
                begin
                    head = due_results.pop_front();
                    checked++;
                    if (value !== head.val)
                        report_mismatch($sformatf("value %h, want %h", value, head.val));
                    if (bad_bound !== head.bad)
                        report_mismatch($sformatf("bad_bound %b, want %b",
                                                  bad_bound, head.bad));
                end
            end
            if (seed_we)
                gen_state = (seed == '0) ? Golden : seed;
            if (in_valid && in_ready)
                due_results.insert(due_results.size(), bounded_draw(bound));
            pending <= due_results.size();
        end
    end

endmodule

// ===== test/bounded_xorshift_random_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for bounded_xorshift_random: drives bounds and seeds, stalls
// the result channel, and gives the verdict. Depends on bxr_pkg, the block and
// bxr_result_checker.
module bounded_xorshift_random_tb;
    import bxr_pkg::*;

    // Generous limit on the whole run; an honest run stays well inside it.
    localparam int unsigned RunLimit    = 1_500_000;
    // Idle stretch after the last result before the verdict.
    localparam int unsigned DrainCycles = 150;
    localparam int unsigned NumCorners  = 20;
    localparam int unsigned SeedPhases  = 6;
    localparam int unsigned PhaseWords  = 130;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [BoundW-1:0] bound     = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BoundW-1:0] value;
    logic              bad_bound;
    logic              seed_we   = 1'b0;
    logic [WordW-1:0]  seed      = '0;

    // Receiver pattern control: free_run keeps out_ready high for a phase.
    logic              free_run  = 1'b0;
    int unsigned       hold_left = 0;

    int unsigned       cycles     = 0;
    int unsigned       words_sent = 0;
    int unsigned       zero_sent  = 0;
    int                fail_count;
    int                pending;
    int                checked;
    int                redraws;

    bounded_xorshift_random u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .bound     (bound),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .bad_bound (bad_bound),
        .seed_we   (seed_we),
        .seed      (seed)
    );

    bxr_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .bound      (bound),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .bad_bound  (bad_bound),
        .seed_we    (seed_we),
        .seed       (seed),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .redraws    (redraws)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RunLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("bounded_xorshift_random: mismatch");
            $finish;
        end
    end

    // Result-side stalls: ready and stalled stretches of random length, picked at
    // random with the stalls longer, unless the phase asks for a free-running sink.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (free_run)
            out_ready <= 1'b1;
        else if ($urandom_range(0, 2) != 0)
        begin
            out_ready <= 1'b1;
            hold_left <= $urandom_range(0, 10);
        end
        else
        begin
            out_ready <= 1'b0;
            hold_left <= $urandom_range(0, 30);
        end
    end

    // Hand-picked bounds: zero, one, the field maximum, powers of two, and
    // bounds just above a third or a quarter of 2^64 where redraws are common.
    function automatic logic [BoundW-1:0] corner_bound(input int unsigned i);
        case (i)
            0:       return '0;
            1:       return 63'd1;
            2:       return 63'h7FFF_FFFF_FFFF_FFFF;
            3:       return 63'd2;
            4:       return '0;
            5:       return 63'd3;
            6:       return 63'h4000_0000_0000_0001;
            7:       return 63'h5555_5555_5555_5556;
            8:       return 63'h4000_0000_0000_0000;
            9:       return 63'd1;
            10:      return 63'h7FFF_FFFF_FFFF_FFFE;
            11:      return 63'h2AAA_AAAA_AAAA_AAAB;
            12:      return 63'h0000_0000_FFFF_FFFF;
            13:      return 63'h0000_0001_0000_0000;
            14:      return 63'd10;
            15:      return 63'h3FFF_FFFF_FFFF_FFFF;
            16:      return 63'd7;
            17:      return 63'h5555_5555_5555_5555;
            18:      return '0;
            default: return 63'h7FFF_FFFF_FFFF_FFFF;
        endcase
    endfunction

    // Random bounds: a few zeros, many tiny ones, a good share in the top two
    // octaves where rejection bites, the rest of random magnitude.
    function automatic logic [BoundW-1:0] pick_bound();
        logic [WordW-1:0] r;
        int unsigned      sel;
        r   = {$urandom, $urandom};
        sel = $urandom_range(0, 99);
        if (sel < 4)
            return '0;
        if (sel < 30)
            return BoundW'($urandom_range(1, 20));
        if (sel < 50)
            return {1'b1, r[BoundW-2:0]};
        if (sel < 60)
            return {2'b01, r[BoundW-3:0]};
        return r[BoundW-1:0] >> $urandom_range(0, BoundW - 1);
    endfunction

    // Seeds per phase: zero (golden fallback), all ones, one, the golden
    // constant itself, and random values.
    function automatic logic [WordW-1:0] phase_seed(input int unsigned p);
        case (p)
            0:       return '0;
            1:       return {WordW{1'b1}};
            2:       return 64'd1;
            4:       return 64'h9E37_79B9_7F4A_7C15;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one word and hold it until taken. The caller either offers the
    // next word or drops valid, never both in the same step.
    task automatic send_word(input logic [BoundW-1:0] b);
        in_valid <= 1'b1;
        bound    <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        if (b == '0)
            zero_sent++;
    endtask

    // Wait until every accepted word has produced its result.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words on the reset seed, back to back.
        for (int unsigned i = 0; i < NumCorners; i++)
            send_word(corner_bound(i));
        in_valid <= 1'b0;

        for (int unsigned p = 0; p < SeedPhases; p++)
        begin
            // Reseed only once the block has handed over everything.
            wait_drained();
            seed_we <= 1'b1;
            seed    <= phase_seed(p);
            @(posedge clk);
            seed_we  <= 1'b0;
            free_run <= p[0];

            // Bursts of random length; a zero gap runs straight on.
            sent = 0;
            while (sent < PhaseWords)
            begin
                burst = $urandom_range(1, 12);
                repeat (burst)
                begin
                    send_word(pick_bound());
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                if (gap != 0)
                begin
                    // Drop valid and scramble the idle bound lines.
                    in_valid <= 1'b0;
                    bound    <= BoundW'({$urandom, $urandom});
                    repeat (gap) @(posedge clk);
                end
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (DrainCycles) @(posedge clk);

        $display("sent %0d bounds (%0d zero) across %0d seed settings plus reset seed",
                 words_sent, zero_sent, SeedPhases);
        $display("checked %0d results, %0d draws redrawn, %0d cycles",
                 checked, redraws, cycles);
        if (fail_count == 0)
            $display("bounded_xorshift_random: match");
        else
            $display("bounded_xorshift_random: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bxr_pkg.sv
sv/bxr_dp.sv
sv/bxr_ctrl.sv
sv/bounded_xorshift_random.sv
test/bxr_result_checker.sv
test/bounded_xorshift_random_tb.sv
